>>> rtl/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// shared widths, register indexes and code conversion for the scan deframer
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int MAX_SLOTS   = 8;
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W       = 4;
    localparam int CHAN_W      = 3;
    localparam int CODE_W      = 12;
    localparam int MV_W        = 15;
    localparam int SCAN_W      = 32;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_LIST       = 1'd1;

    localparam logic [MV_W-1:0] MV_OFFSET  = 15'd10000;
    localparam logic [11:0]     FULL_SCALE = 12'd2047;

    // floor(code * 10000 / 2047) - 10000, division folded on 2047 = 2^11 - 1
    function automatic logic [MV_W-1:0] f_to_mv(input logic [CODE_W-1:0] code);
        logic [25:0]     x;
        logic [14:0]     a;
        logic [15:0]     s;
        logic [4:0]      a2;
        logic [11:0]     s2;
        logic [MV_W-1:0] q;
        x  = 26'(code) * 26'd10000;
        a  = x[25:11];
        s  = 16'(a) + 16'(x[10:0]);
        a2 = s[15:11];
        s2 = 12'(a2) + 12'(s[10:0]);
        q  = a + 15'(a2) + ((s2 >= FULL_SCALE) ? 15'd1 : 15'd0);
        return q - MV_OFFSET;
    endfunction

endpackage

>>> rtl/adc_scan_stream_deframer_unit.sv
// ----------------------------------------------------------------------------
// adc_scan_stream_deframer_unit
// pairs converter bytes into words and emits one sample per word
// ----------------------------------------------------------------------------
// slave channel takes one converter byte per beat; master channel gives one
// sample per completed word (low byte then high byte). scan start words carry
// bit 0 of the low byte clear, other words carry it set.
// a byte is taken in every cycle while the output register is empty or being
// drained; a sample shows up in the cycle after its high byte is accepted,
// and the deframer sustains one byte per cycle while the receiver keeps up.
// two beats make one word, which sets the sample rate; a draining result
// register frees s_axis_tready in the same cycle.
// a bad sync bit at scan start makes the block hunt for a byte with bit 0
// clear, drop the rest of that scan, and restart the scan count at zero.
// when the receiver stalls, the held sample stays put and s_axis_tready drops
// until it is taken.
// reset is synchronous: the block comes up aligned, one word per scan, scan
// list zero, no sample pending. config writes belong in idle periods.
// ----------------------------------------------------------------------------
module adc_scan_stream_deframer_unit
    import asd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // rx_byte[7:0]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // channel[2:0], raw_code[14:3], millivolts[29:15], scan_number[61:30], zero
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                    m_axis_tlast,   // last_in_scan
    output logic                    m_axis_tuser    // sync_error
);

    typedef enum logic [1:0] {
        ST_ALIGNED  = 2'd0,
        ST_HUNTING  = 2'd1,
        ST_SKIPPING = 2'd2
    } t_mode;

    t_mode               r_mode, n_mode;
    logic                r_phase, n_phase;
    logic [7:0]          r_low, n_low;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]    r_skip, n_skip;
    logic [SCAN_W-1:0]   r_scan, n_scan;
    logic [CNT_W-1:0]    r_active;
    logic [CFG_W-1:0]    r_scan_list;

    logic                r_out_valid, n_out_valid;
    logic [CHAN_W-1:0]   r_chan, n_chan;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [MV_W-1:0]     r_mv, n_mv;
    logic [SCAN_W-1:0]   r_out_scan, n_out_scan;
    logic                r_last, n_last;
    logic                r_err, n_err;

    logic                in_beat;
    logic [CNT_W-1:0]    words;
    logic [7:0]          rx;
    logic [CODE_W-1:0]   code;
    logic                last;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;

    always_comb begin
        if (r_active == '0) begin
            words = CNT_W'(1);
        end else if (r_active > CNT_W'(MAX_SLOTS)) begin
            words = CNT_W'(MAX_SLOTS);
        end else begin
            words = r_active;
        end
    end

    assign code = {rx[7:1], r_low[7:3]};
    assign last = (CNT_W'(r_slot) + CNT_W'(1)) >= words;

    always_comb begin
        n_mode      = r_mode;
        n_phase     = r_phase;
        n_low       = r_low;
        n_slot      = r_slot;
        n_skip      = r_skip;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_chan      = r_chan;
        n_code      = r_code;
        n_mv        = r_mv;
        n_out_scan  = r_out_scan;
        n_last      = r_last;
        n_err       = r_err;
        if (in_beat) begin
            unique case (r_mode)
                ST_SKIPPING: begin
                    n_skip = r_skip - CNT_W'(1);
                    if (n_skip == '0) begin
                        n_mode  = ST_ALIGNED;
                        n_phase = 1'b0;
                        n_slot  = '0;
                        n_scan  = '0;
                    end
                end
                ST_HUNTING: begin
                    if (!rx[0]) begin
                        n_skip = CNT_W'({words, 1'b0} - 5'd1);
                        n_mode = ST_SKIPPING;
                    end
                end
                ST_ALIGNED: begin
                    if (!r_phase) begin
                        if (r_slot == '0 && rx[0]) begin
                            n_mode = ST_HUNTING;
                        end else begin
                            n_low   = rx;
                            n_phase = 1'b1;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_chan      = r_scan_list[5'(r_slot) * 5'd3 +: CHAN_W];
                        n_code      = code;
                        n_mv        = f_to_mv(code);
                        n_out_scan  = r_scan;
                        n_last      = last;
                        n_err       = (r_slot != '0) && !r_low[0];
                        n_phase     = 1'b0;
                        if (last) begin
                            n_slot = '0;
                            n_scan = r_scan + SCAN_W'(1);
                        end else begin
                            n_slot = r_slot + SLOT_W'(1);
                        end
                    end
                end
                default: begin
                    n_mode = ST_HUNTING;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ST_ALIGNED;
            r_phase     <= 1'b0;
            r_low       <= '0;
            r_slot      <= '0;
            r_skip      <= '0;
            r_scan      <= '0;
            r_active    <= CNT_W'(1);
            r_scan_list <= '0;
            r_out_valid <= 1'b0;
            r_chan      <= '0;
            r_code      <= '0;
            r_mv        <= '0;
            r_out_scan  <= '0;
            r_last      <= 1'b0;
            r_err       <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_low       <= n_low;
            r_slot      <= n_slot;
            r_skip      <= n_skip;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
            r_chan      <= n_chan;
            r_code      <= n_code;
            r_mv        <= n_mv;
            r_out_scan  <= n_out_scan;
            r_last      <= n_last;
            r_err       <= n_err;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ACTIVE_CHANNELS: r_active    <= i_cfg_wdata[CNT_W-1:0];
                    REG_SCAN_LIST:       r_scan_list <= i_cfg_wdata;
                    default:             r_active    <= r_active;
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_scan, r_mv, r_code, r_chan};
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_err;

endmodule

>>> rtl/asd_checker.sv
// ----------------------------------------------------------------------------
// asd_checker
// port-level checks for the scan deframer, bound to the top level
// ----------------------------------------------------------------------------
module asd_checker
    import asd_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_axis_tready,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                    m_axis_tlast,
    input logic                    m_axis_tuser
);

    // held beat stays intact under stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled beat changed");

    // nothing pending right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("beat pending after reset");

    // empty output register never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input blocked with free output");

    // millivolts agree with the code in the same beat
    a_mv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[29:15] == f_to_mv(m_axis_tdata[14:3]))
        else $error("millivolts mismatch");

endmodule

bind adc_scan_stream_deframer_unit asd_checker u_asd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
